@@ hw/rtl/i2csb_pkg.sv @@
// shared types and constants for the two-wire slave buffer handler
// status codes, opcodes, bus actions and the item, result and write structs
// no dependencies
package i2csb_pkg;

  localparam logic [1:0] OP_BUS_EVENT    = 2'd0;
  localparam logic [1:0] OP_REPLY_WRITE  = 2'd1;
  localparam logic [1:0] OP_REPLY_COMMIT = 2'd2;

  localparam logic [7:0] ST_SRX_ADR_ACK   = 8'h60;
  localparam logic [7:0] ST_SRX_DATA_ACK  = 8'h80;
  localparam logic [7:0] ST_SRX_STOP      = 8'hA0;
  localparam logic [7:0] ST_STX_ADR_ACK   = 8'hA8;
  localparam logic [7:0] ST_STX_DATA_ACK  = 8'hB8;
  localparam logic [7:0] ST_STX_DATA_NACK = 8'hC0;
  localparam logic [7:0] ST_NO_STATE      = 8'hF8;
  localparam logic [7:0] ST_BUS_ERROR     = 8'h00;

  localparam logic [1:0] ACT_RELEASE_ACK  = 2'd0;
  localparam logic [1:0] ACT_RELEASE_KEEP = 2'd1;
  localparam logic [1:0] ACT_STOP_REINIT  = 2'd2;

  localparam logic [7:0] TX_FILL_BYTE = 8'hFF;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] bus_status;
    logic [7:0] bus_byte;
    logic [3:0] reply_index;
    logic [7:0] reply_byte;
    logic [7:0] reply_length;
  } item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [4:0] rx_index;
    logic [7:0] rx_byte;
    logic       command_ready;
    logic       read_busy;
    logic [1:0] bus_action;
  } result_t;

  typedef struct packed {
    logic       en;
    logic [3:0] idx;
    logic [7:0] data;
  } wr_req_t;

endpackage

@@ hw/rtl/i2csb_reply_mem.sv @@
// reply byte store with a registered read port
// the read port follows the next send pointer so the entry at the current
// pointer is always ready; same-edge writes are forwarded. uses i2csb_pkg
module i2csb_reply_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned PW    = 5
) (
  input  logic                  clk_i,
  input  i2csb_pkg::wr_req_t    wr_i,
  input  logic [PW-1:0]         rd_ptr_i,
  output logic [7:0]            rd_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_q;
  logic       wr_ok;
  logic       fwd;

  assign wr_ok = wr_i.en && (8'(wr_i.idx) < 8'(DEPTH));
  assign fwd   = wr_ok && (8'(wr_i.idx) == 8'(rd_ptr_i));

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem[AW'(wr_i.idx)] <= wr_i.data;
    end
    if (fwd) begin
      rd_data_q <= wr_i.data;
    end else begin
      rd_data_q <= mem[AW'(rd_ptr_i)];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hw/rtl/i2csb_event_unit.sv @@
// status event decode and pointer state for the two-wire slave handler
// computes one result per item and updates state when the item advances
// uses i2csb_pkg
module i2csb_event_unit #(
  parameter int unsigned REPLY_DEPTH   = 16,
  parameter int unsigned RECEIVE_DEPTH = 32,
  parameter int unsigned PW            = 5,
  parameter int unsigned RW            = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  i2csb_pkg::item_t    item_i,
  input  logic [7:0]          rd_data_i,
  output i2csb_pkg::result_t  result_o,
  output i2csb_pkg::wr_req_t  wr_o,
  output logic [PW-1:0]       send_ptr_d_o,
  output logic                busy_o
);

  logic [PW-1:0] send_ptr_q, send_ptr_d;
  logic [PW-1:0] reply_cnt_q, reply_cnt_d;
  logic [RW-1:0] rcv_ptr_q, rcv_ptr_d;
  logic          rcv_open_q, rcv_open_d;
  logic          addressed_q, addressed_d;
  logic          busy_q, busy_d;
  logic          open_now;
  i2csb_pkg::result_t res;

  always_comb begin
    send_ptr_d  = send_ptr_q;
    reply_cnt_d = reply_cnt_q;
    rcv_ptr_d   = rcv_ptr_q;
    rcv_open_d  = rcv_open_q;
    addressed_d = addressed_q;
    busy_d      = busy_q;
    open_now    = rcv_open_q;
    res         = '0;

    case (item_i.opcode)
      i2csb_pkg::OP_REPLY_WRITE: begin
      end
      i2csb_pkg::OP_REPLY_COMMIT: begin
        // clamp the length to the store depth
        if (32'(item_i.reply_length) > REPLY_DEPTH) begin
          reply_cnt_d = PW'(REPLY_DEPTH);
        end else begin
          reply_cnt_d = PW'(item_i.reply_length);
        end
        busy_d = 1'b1;
      end
      i2csb_pkg::OP_BUS_EVENT: begin
        case (item_i.bus_status)
          i2csb_pkg::ST_STX_ADR_ACK: begin
            send_ptr_d = '0;
            busy_d     = 1'b1;
          end
          i2csb_pkg::ST_STX_DATA_NACK: begin
            busy_d = 1'b0;
          end
          i2csb_pkg::ST_STX_DATA_ACK: begin
            res.tx_valid   = 1'b1;
            res.bus_action = i2csb_pkg::ACT_RELEASE_KEEP;
            if (send_ptr_q >= reply_cnt_q || 32'(send_ptr_q) >= REPLY_DEPTH) begin
              res.tx_byte = i2csb_pkg::TX_FILL_BYTE;
            end else begin
              res.tx_byte = rd_data_i;
              send_ptr_d  = send_ptr_q + PW'(1);
            end
          end
          i2csb_pkg::ST_SRX_STOP: begin
            res.command_ready = addressed_q;
          end
          i2csb_pkg::ST_SRX_ADR_ACK: begin
            rcv_ptr_d   = '0;
            rcv_open_d  = 1'b1;
            addressed_d = 1'b1;
          end
          i2csb_pkg::ST_SRX_DATA_ACK: begin
            // buffer full closes it for the rest of the transaction
            if (32'(rcv_ptr_q) >= RECEIVE_DEPTH) begin
              open_now = 1'b0;
            end
            rcv_open_d = open_now;
            if (open_now) begin
              res.rx_valid = 1'b1;
              res.rx_index = 5'(rcv_ptr_q);
              res.rx_byte  = item_i.bus_byte;
              rcv_ptr_d    = rcv_ptr_q + RW'(1);
            end
          end
          i2csb_pkg::ST_NO_STATE, i2csb_pkg::ST_BUS_ERROR: begin
            busy_d         = 1'b0;
            res.bus_action = i2csb_pkg::ACT_STOP_REINIT;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    res.read_busy = busy_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      send_ptr_q  <= '0;
      reply_cnt_q <= '0;
      rcv_ptr_q   <= '0;
      rcv_open_q  <= 1'b0;
      addressed_q <= 1'b0;
      busy_q      <= 1'b0;
    end else if (adv_i) begin
      send_ptr_q  <= send_ptr_d;
      reply_cnt_q <= reply_cnt_d;
      rcv_ptr_q   <= rcv_ptr_d;
      rcv_open_q  <= rcv_open_d;
      addressed_q <= addressed_d;
      busy_q      <= busy_d;
    end
  end

  assign result_o     = res;
  assign wr_o.en      = adv_i && (item_i.opcode == i2csb_pkg::OP_REPLY_WRITE);
  assign wr_o.idx     = item_i.reply_index;
  assign wr_o.data    = item_i.reply_byte;
  assign send_ptr_d_o = adv_i ? send_ptr_d : send_ptr_q;
  assign busy_o       = busy_q;

endmodule

@@ hw/rtl/i2c_slave_buffer_handler.sv @@
// an accepted item is held in the item register; its result is loaded into the
// output register once the output is free. throughput: one item per cycle
// unless the output stalls; the reply store read port is prefetched at the next
// send pointer so a data acknowledge never waits on the memory
// reset: asynchronous, active low; pointers, counts and flags clear to zero,
// the reply store is not cleared and reads undefined until written
module i2c_slave_buffer_handler #(
  parameter int unsigned REPLY_DEPTH   = 16,
  parameter int unsigned RECEIVE_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // bus_status [7:0], bus_byte [15:8], reply_index [19:16], reply_byte [27:20],
  // reply_length [35:28], zero [39:36]
  input  logic [39:0] s_axis_tdata,
  // opcode [1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tx_valid [0], tx_byte [8:1], rx_valid [9], rx_index [14:10], rx_byte [22:15],
  // command_ready [23], read_busy [24], bus_action [26:25], zero [31:27]
  output logic [31:0] m_axis_tdata
);

  localparam int unsigned PW = $clog2(REPLY_DEPTH + 1);
  localparam int unsigned RW = $clog2(RECEIVE_DEPTH + 1);

  i2csb_pkg::item_t   item_q;
  logic               item_v_q;
  i2csb_pkg::result_t out_q;
  logic               out_v_q;
  i2csb_pkg::result_t result;
  i2csb_pkg::wr_req_t wr_req;
  logic [PW-1:0]      send_ptr_d;
  logic [7:0]         rd_data;
  logic               busy;
  logic               s_fire;
  logic               adv;

  assign adv           = item_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !item_v_q || adv;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (s_fire) begin
        item_v_q <= 1'b1;
      end else if (adv) begin
        item_v_q <= 1'b0;
      end
      if (adv) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      item_q.opcode       <= s_axis_tuser;
      item_q.bus_status   <= s_axis_tdata[7:0];
      item_q.bus_byte     <= s_axis_tdata[15:8];
      item_q.reply_index  <= s_axis_tdata[19:16];
      item_q.reply_byte   <= s_axis_tdata[27:20];
      item_q.reply_length <= s_axis_tdata[35:28];
    end
    if (adv) begin
      out_q <= result;
    end
  end

  i2csb_event_unit #(
    .REPLY_DEPTH  (REPLY_DEPTH),
    .RECEIVE_DEPTH(RECEIVE_DEPTH),
    .PW           (PW),
    .RW           (RW)
  ) u_event (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .item_i      (item_q),
    .rd_data_i   (rd_data),
    .result_o    (result),
    .wr_o        (wr_req),
    .send_ptr_d_o(send_ptr_d),
    .busy_o      (busy)
  );

  i2csb_reply_mem #(
    .DEPTH(REPLY_DEPTH),
    .PW   (PW)
  ) u_reply_mem (
    .clk_i    (clk_i),
    .wr_i     (wr_req),
    .rd_ptr_i (send_ptr_d),
    .rd_data_o(rd_data)
  );

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {5'd0, out_q.bus_action, out_q.read_busy, out_q.command_ready,
                          out_q.rx_byte, out_q.rx_index, out_q.rx_valid,
                          out_q.tx_byte, out_q.tx_valid};

  // a commit always leaves the reply pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && item_q.opcode == i2csb_pkg::OP_REPLY_COMMIT |=> busy)
    else $error("reply commit did not set busy");

  // a transmitted byte always keeps the ack released
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.tx_valid |-> out_q.bus_action == i2csb_pkg::ACT_RELEASE_KEEP)
    else $error("tx byte without keep-ack action");

  // one event never both stores and sends a byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> !(out_q.tx_valid && out_q.rx_valid))
    else $error("tx and rx in one result");

  // the reported busy flag matches the state after the item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_q.read_busy == busy)
    else $error("read_busy differs from busy state");

endmodule
